FILE: sv/rtqi_pkg.sv
// Package for the ray/triangle/quad intersection pipeline.
// Holds shared widths, register indexes, the configuration struct and the pipeline depth.
// No dependencies.
package rtqi_pkg;

    localparam int COORD_WIDTH_DEF = 20;
    localparam int FRAC_BITS_DEF   = 10;
    localparam int VEC_WIDTH       = 60;
    localparam int CFG_WIDTH       = 20;
    localparam int Q_FRAC          = 20;   // fraction bits of u, v and t
    localparam int UV_BITS         = 22;   // u and v saturate at 2^UV_BITS
    localparam int T_BITS          = 40;   // distance width
    localparam int IN_DATA_WIDTH   = 6 * VEC_WIDTH;
    localparam int OUT_DATA_WIDTH  = T_BITS;

    // six front stages, one divider setup stage, T_BITS divider stages, one check stage
    localparam int TRI_LATENCY     = T_BITS + 8;

    localparam logic [0:0] REG_PARALLEL = 1'b0;
    localparam logic [0:0] REG_TOL      = 1'b1;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] parallel_threshold;
        logic [CFG_WIDTH-1:0] bary_tolerance;
    } cfg_t;

endpackage

FILE: sv/ray_triangle_quad_intersect.sv
// Top level of the ray/triangle/quad intersection pipeline.
// Two triangle pipelines (abc and acd) run side by side; the output register picks the first hit.
// Depends on rtqi_pkg and rtqi_tri.
//
//  channel   | direction | handshake         | payload
//  ----------+-----------+-------------------+----------------------------------------------
//  s_*       | in        | s_tvalid/s_tready | tdata: origin, direction, a, b, c, d; tuser: is_quad
//  m_*       | out       | m_tvalid/m_tready | tdata: distance; tuser: hit, second_triangle
//  cfg_*     | in        | cfg_we            | cfg_index selects register, cfg_wdata value
//
// One word per cycle enters while the pipeline is not stalled; results leave in input order.
// The depth is set by the divider: one quotient bit per stage for the 40-bit distance.
// Every stage advances together whenever the output register is empty or being taken.
// Reset clears the valid bits and loads both thresholds with 1; no clearing pass.
module ray_triangle_quad_intersect #(
    parameter int COORD_WIDTH = rtqi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rtqi_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // ray_origin, ray_direction, vertex_a, vertex_b, vertex_c, vertex_d (60 bits each)
    input  logic [rtqi_pkg::IN_DATA_WIDTH-1:0]     s_tdata,
    // is_quad
    input  logic [0:0]                             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // distance
    output logic [rtqi_pkg::OUT_DATA_WIDTH-1:0]    m_tdata,
    // hit, second_triangle
    output logic [1:0]                             m_tuser,
    input  logic                                   cfg_we,
    input  logic [0:0]                             cfg_index,
    input  logic [rtqi_pkg::CFG_WIDTH-1:0]         cfg_wdata
);
    import rtqi_pkg::*;

    localparam int VW = 3 * COORD_WIDTH;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.parallel_threshold <= CFG_WIDTH'(1);
            cfg_reg.bary_tolerance     <= CFG_WIDTH'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PARALLEL: cfg_reg.parallel_threshold <= cfg_wdata;
                REG_TOL:      cfg_reg.bary_tolerance     <= cfg_wdata;
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    logic ce;
    logic out_valid_reg;

    assign ce       = !out_valid_reg || m_tready;
    assign s_tready = ce;

    logic [VW-1:0] org;
    logic [VW-1:0] dir;
    logic [VW-1:0] va;
    logic [VW-1:0] vb;
    logic [VW-1:0] vc;
    logic [VW-1:0] vd;

    assign org = VW'(s_tdata[0*VEC_WIDTH +: VEC_WIDTH]);
    assign dir = VW'(s_tdata[1*VEC_WIDTH +: VEC_WIDTH]);
    assign va  = VW'(s_tdata[2*VEC_WIDTH +: VEC_WIDTH]);
    assign vb  = VW'(s_tdata[3*VEC_WIDTH +: VEC_WIDTH]);
    assign vc  = VW'(s_tdata[4*VEC_WIDTH +: VEC_WIDTH]);
    assign vd  = VW'(s_tdata[5*VEC_WIDTH +: VEC_WIDTH]);

    logic              hit0;
    logic              hit1;
    logic [T_BITS-1:0] dist0;
    logic [T_BITS-1:0] dist1;

    rtqi_tri #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_tri_abc (
        .clk      (clk),
        .ce       (ce),
        .cfg      (cfg_reg),
        .org      (org),
        .dir      (dir),
        .va       (va),
        .vb       (vb),
        .vc       (vc),
        .hit      (hit0),
        .distance (dist0)
    );

    rtqi_tri #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_tri_acd (
        .clk      (clk),
        .ce       (ce),
        .cfg      (cfg_reg),
        .org      (org),
        .dir      (dir),
        .va       (va),
        .vb       (vc),
        .vc       (vd),
        .hit      (hit1),
        .distance (dist1)
    );

    logic [TRI_LATENCY-1:0] vld_reg;
    logic [TRI_LATENCY-1:0] quad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[TRI_LATENCY-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            quad_reg <= {quad_reg[TRI_LATENCY-2:0], s_tuser[0]};
        end
    end

    logic              use_second;
    logic              hit_next;
    logic [T_BITS-1:0] dist_next;

    always_comb
    begin
        use_second = !hit0 && quad_reg[TRI_LATENCY-1] && hit1;
        hit_next   = hit0 || use_second;
        dist_next  = hit0 ? dist0 : (use_second ? dist1 : '0);
    end

    logic [T_BITS-1:0] dist_reg;
    logic              hit_reg;
    logic              second_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            out_valid_reg <= vld_reg[TRI_LATENCY-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dist_reg   <= dist_next;
            hit_reg    <= hit_next;
            second_reg <= use_second;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = dist_reg;
    assign m_tuser  = {second_reg, hit_reg};

    a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
        else $error("miss carries a distance or triangle flag");

    a_second_hit : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("second triangle flagged without a hit");

    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !ce |=> vld_reg == $past(vld_reg))
        else $error("pipeline moved during a stall");

endmodule

FILE: sv/rtqi_tri.sv
// One Moller-Trumbore triangle test as a fixed-latency pipeline.
// Front stages form edges, cross and dot products; restoring divider stages follow.
// Depends on rtqi_pkg.
module rtqi_tri #(
    parameter int COORD_WIDTH = rtqi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rtqi_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         ce,
    input  rtqi_pkg::cfg_t               cfg,
    input  logic [3*COORD_WIDTH-1:0]     org,
    input  logic [3*COORD_WIDTH-1:0]     dir,
    input  logic [3*COORD_WIDTH-1:0]     va,
    input  logic [3*COORD_WIDTH-1:0]     vb,
    input  logic [3*COORD_WIDTH-1:0]     vc,
    output logic                         hit,
    output logic [rtqi_pkg::T_BITS-1:0]  distance
);
    import rtqi_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int EW = W + 1;
    localparam int PX = 2 * EW;
    localparam int XW = PX + 1;
    localparam int PW = XW - FRAC_BITS;
    localparam int MW = EW + PW;
    localparam int DW = MW + 2;
    localparam int UQ = UV_BITS + 1;
    localparam int SW = UQ + 3;

    typedef logic signed [EW-1:0] ecomp_t;

    typedef struct packed {
        logic [DW-1:0]     r;
        logic [T_BITS-1:0] x;
        logic [T_BITS-1:0] q;
    } div_t;

    typedef struct packed {
        logic [DW-1:0] den;
        div_t          du;
        div_t          dv;
        div_t          dt;
        logic          usat;
        logic          vsat;
        logic          tsat;
        logic          uneg;
        logic          vneg;
        logic          par_miss;
        logic          nt_bad;
    } dstage_t;

    function automatic div_t div_step(div_t s, logic [DW-1:0] den);
        logic [DW:0] tr;
        logic        ge;
        div_t        n;
        tr   = {s.r, s.x[T_BITS-1]};
        ge   = (tr >= {1'b0, den});
        n.r  = ge ? DW'(tr - {1'b0, den}) : DW'(tr);
        n.x  = s.x << 1;
        n.q  = {s.q[T_BITS-2:0], ge};
        return n;
    endfunction

    // stage 1: edges
    logic signed [W-1:0] o_c [3];
    logic signed [W-1:0] d_c [3];
    logic signed [W-1:0] a_c [3];
    logic signed [W-1:0] b_c [3];
    logic signed [W-1:0] c_c [3];

    ecomp_t e1_reg [3];
    ecomp_t e2_reg [3];
    ecomp_t s_reg  [3];
    ecomp_t d_reg  [3];

    // stage 2: cross products terms
    logic signed [PX-1:0] pp1_reg [3];
    logic signed [PX-1:0] pp2_reg [3];
    logic signed [PX-1:0] qp1_reg [3];
    logic signed [PX-1:0] qp2_reg [3];
    ecomp_t e1b_reg [3];
    ecomp_t e2b_reg [3];
    ecomp_t sb_reg  [3];
    ecomp_t db_reg  [3];

    // stage 3: floored cross products
    logic signed [XW-1:0] pdiff [3];
    logic signed [XW-1:0] qdiff [3];
    logic signed [PW-1:0] p_reg [3];
    logic signed [PW-1:0] q_reg [3];
    ecomp_t e1c_reg [3];
    ecomp_t e2c_reg [3];
    ecomp_t sc_reg  [3];
    ecomp_t dc_reg  [3];

    // stage 4: dot product terms
    logic signed [MW-1:0] mdet_reg [3];
    logic signed [MW-1:0] mnu_reg  [3];
    logic signed [MW-1:0] mnv_reg  [3];
    logic signed [MW-1:0] mnt_reg  [3];

    for (genvar k = 0; k < 3; k++) begin : g_comp
        localparam int I1 = (k + 1) % 3;
        localparam int I2 = (k + 2) % 3;

        assign o_c[k] = $signed(org[k*W +: W]);
        assign d_c[k] = $signed(dir[k*W +: W]);
        assign a_c[k] = $signed(va[k*W +: W]);
        assign b_c[k] = $signed(vb[k*W +: W]);
        assign c_c[k] = $signed(vc[k*W +: W]);

        assign pdiff[k] = XW'(pp1_reg[k]) - XW'(pp2_reg[k]);
        assign qdiff[k] = XW'(qp1_reg[k]) - XW'(qp2_reg[k]);

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                e1_reg[k]  <= EW'(b_c[k]) - EW'(a_c[k]);
                e2_reg[k]  <= EW'(c_c[k]) - EW'(a_c[k]);
                s_reg[k]   <= EW'(o_c[k]) - EW'(a_c[k]);
                d_reg[k]   <= EW'(d_c[k]);

                pp1_reg[k] <= d_reg[I1] * e2_reg[I2];
                pp2_reg[k] <= d_reg[I2] * e2_reg[I1];
                qp1_reg[k] <= s_reg[I1] * e1_reg[I2];
                qp2_reg[k] <= s_reg[I2] * e1_reg[I1];
                e1b_reg[k] <= e1_reg[k];
                e2b_reg[k] <= e2_reg[k];
                sb_reg[k]  <= s_reg[k];
                db_reg[k]  <= d_reg[k];

                p_reg[k]   <= PW'(pdiff[k] >>> FRAC_BITS);
                q_reg[k]   <= PW'(qdiff[k] >>> FRAC_BITS);
                e1c_reg[k] <= e1b_reg[k];
                e2c_reg[k] <= e2b_reg[k];
                sc_reg[k]  <= sb_reg[k];
                dc_reg[k]  <= db_reg[k];

                mdet_reg[k] <= e1c_reg[k] * p_reg[k];
                mnu_reg[k]  <= sc_reg[k] * p_reg[k];
                mnv_reg[k]  <= dc_reg[k] * q_reg[k];
                mnt_reg[k]  <= e2c_reg[k] * q_reg[k];
            end
        end
    end

    // stage 5: sums
    logic signed [DW-1:0] det_reg;
    logic signed [DW-1:0] nu_reg;
    logic signed [DW-1:0] nv_reg;
    logic signed [DW-1:0] nt_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            det_reg <= DW'(mdet_reg[0]) + DW'(mdet_reg[1]) + DW'(mdet_reg[2]);
            nu_reg  <= DW'(mnu_reg[0]) + DW'(mnu_reg[1]) + DW'(mnu_reg[2]);
            nv_reg  <= DW'(mnv_reg[0]) + DW'(mnv_reg[1]) + DW'(mnv_reg[2]);
            nt_reg  <= DW'(mnt_reg[0]) + DW'(mnt_reg[1]) + DW'(mnt_reg[2]);
        end
    end

    // stage 6: make det positive, split the u and v numerators into sign and magnitude
    logic                 det_neg;
    logic signed [DW-1:0] nu_n;
    logic signed [DW-1:0] nv_n;
    logic signed [DW-1:0] nt_n;
    logic [DW-1:0]        den_next;

    logic [DW-1:0] den_reg;
    logic [DW-1:0] unum_reg;
    logic [DW-1:0] vnum_reg;
    logic [DW-1:0] tnum_reg;
    logic          uneg_reg;
    logic          vneg_reg;
    logic          par_miss_reg;
    logic          nt_bad_reg;

    always_comb
    begin
        det_neg  = det_reg[DW-1];
        den_next = det_neg ? DW'(-det_reg) : DW'(det_reg);
        nu_n     = det_neg ? -nu_reg : nu_reg;
        nv_n     = det_neg ? -nv_reg : nv_reg;
        nt_n     = det_neg ? -nt_reg : nt_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            den_reg      <= den_next;
            uneg_reg     <= nu_n[DW-1];
            vneg_reg     <= nv_n[DW-1];
            unum_reg     <= nu_n[DW-1] ? DW'(-nu_n) : DW'(nu_n);
            vnum_reg     <= nv_n[DW-1] ? DW'(-nv_n) : DW'(nv_n);
            tnum_reg     <= DW'(nt_n);
            nt_bad_reg   <= nt_n[DW-1] || (nt_n == '0);
            par_miss_reg <= (den_next == '0) || (den_next < DW'(cfg.parallel_threshold));
        end
    end

    // stage 7 sets up the dividers; each divider stage adds one quotient bit (u and v: first UV_BITS only)
    dstage_t dv_reg [T_BITS+1];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dv_reg[0].den      <= den_reg;
            dv_reg[0].usat     <= (unum_reg >> (UV_BITS - Q_FRAC)) >= den_reg;
            dv_reg[0].vsat     <= (vnum_reg >> (UV_BITS - Q_FRAC)) >= den_reg;
            dv_reg[0].tsat     <= (tnum_reg >> (T_BITS - Q_FRAC)) >= den_reg;
            dv_reg[0].du.r     <= DW'(unum_reg >> (UV_BITS - Q_FRAC));
            dv_reg[0].dv.r     <= DW'(vnum_reg >> (UV_BITS - Q_FRAC));
            dv_reg[0].dt.r     <= DW'(tnum_reg >> (T_BITS - Q_FRAC));
            dv_reg[0].du.x     <= {UV_BITS'({unum_reg, {Q_FRAC{1'b0}}}),
                                   {(T_BITS - UV_BITS){1'b0}}};
            dv_reg[0].dv.x     <= {UV_BITS'({vnum_reg, {Q_FRAC{1'b0}}}),
                                   {(T_BITS - UV_BITS){1'b0}}};
            dv_reg[0].dt.x     <= T_BITS'({tnum_reg, {Q_FRAC{1'b0}}});
            dv_reg[0].du.q     <= '0;
            dv_reg[0].dv.q     <= '0;
            dv_reg[0].dt.q     <= '0;
            dv_reg[0].uneg     <= uneg_reg;
            dv_reg[0].vneg     <= vneg_reg;
            dv_reg[0].par_miss <= par_miss_reg;
            dv_reg[0].nt_bad   <= nt_bad_reg;
        end
    end

    for (genvar j = 1; j <= T_BITS; j++) begin : g_div
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                dv_reg[j].den      <= dv_reg[j-1].den;
                dv_reg[j].usat     <= dv_reg[j-1].usat;
                dv_reg[j].vsat     <= dv_reg[j-1].vsat;
                dv_reg[j].tsat     <= dv_reg[j-1].tsat;
                dv_reg[j].uneg     <= dv_reg[j-1].uneg;
                dv_reg[j].vneg     <= dv_reg[j-1].vneg;
                dv_reg[j].par_miss <= dv_reg[j-1].par_miss;
                dv_reg[j].nt_bad   <= dv_reg[j-1].nt_bad;
                dv_reg[j].dt       <= div_step(dv_reg[j-1].dt, dv_reg[j-1].den);
                if (j <= UV_BITS)
                begin
                    dv_reg[j].du <= div_step(dv_reg[j-1].du, dv_reg[j-1].den);
                    dv_reg[j].dv <= div_step(dv_reg[j-1].dv, dv_reg[j-1].den);
                end
                else
                begin
                    // hold finished u and v quotients
                    dv_reg[j].du <= dv_reg[j-1].du;
                    dv_reg[j].dv <= dv_reg[j-1].dv;
                end
            end
        end
    end

    // final stage: bounds checks
    localparam logic signed [SW-1:0] ONE_S = SW'(1) << Q_FRAC;

    dstage_t              fin;
    logic [UQ-1:0]        uq;
    logic [UQ-1:0]        vq;
    logic [SW-1:0]        u_ext;
    logic [SW-1:0]        v_ext;
    logic signed [SW-1:0] us;
    logic signed [SW-1:0] vs;
    logic signed [SW-1:0] tol_s;
    logic [T_BITS-1:0]    tq;
    logic                 miss_bary;
    logic                 miss_t;
    logic                 hit_next;

    logic                 hit_reg;
    logic [T_BITS-1:0]    dist_reg;

    always_comb
    begin
        fin   = dv_reg[T_BITS];
        uq    = fin.usat ? UQ'({1'b1, {UV_BITS{1'b0}}}) : UQ'(fin.du.q[UV_BITS-1:0]);
        vq    = fin.vsat ? UQ'({1'b1, {UV_BITS{1'b0}}}) : UQ'(fin.dv.q[UV_BITS-1:0]);
        u_ext = SW'(uq);
        v_ext = SW'(vq);
        us    = fin.uneg ? -u_ext : u_ext;
        vs    = fin.vneg ? -v_ext : v_ext;
        tol_s = SW'(cfg.bary_tolerance);
        tq    = fin.tsat ? '1 : fin.dt.q;
        miss_bary = (us + tol_s < 0) || (us > ONE_S + tol_s)
                 || (vs + tol_s < 0) || (us + vs > ONE_S + tol_s);
        miss_t    = fin.nt_bad || (tq <= T_BITS'(cfg.bary_tolerance));
        hit_next  = !fin.par_miss && !miss_bary && !miss_t;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            hit_reg  <= hit_next;
            dist_reg <= hit_next ? tq : '0;
        end
    end

    assign hit      = hit_reg;
    assign distance = dist_reg;

endmodule

FILE: bench/ray_triangle_quad_intersect_check.sv
// Checker for the ray/triangle/quad intersection block: watches the input, output and
// register write channels, predicts each result and compares it field by field.
// Depends on rtqi_pkg.
module ray_triangle_quad_intersect_check (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [rtqi_pkg::IN_DATA_WIDTH-1:0]  s_tdata,
    input  logic [0:0]                          s_tuser,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [rtqi_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
    input  logic [1:0]                          m_tuser,
    input  logic                                cfg_we,
    input  logic [0:0]                          cfg_index,
    input  logic [rtqi_pkg::CFG_WIDTH-1:0]      cfg_wdata,
    output int                                  fails,
    output int                                  pending,
    output int                                  hits,
    output int                                  quad_hits
);
    timeunit 1ns;
    timeprecision 1ps;
    import rtqi_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam longint unsigned UV_CAP = 64'd1 << UV_BITS;
    localparam longint unsigned T_MAX  = (64'd1 << T_BITS) - 1;
    localparam longint ONE = 64'sd1 << Q_FRAC;

    typedef struct {
        longint x, y, z;
    } vec_t;

    typedef struct {
        logic            hit;
        logic [T_BITS-1:0] distance;
        logic            second;
    } isect_t;

    cfg_t   cfg;
    isect_t expected_q[$];
    int     n_out;

    function automatic vec_t unpack_vec(logic [VEC_WIDTH-1:0] p);
        vec_t r;
        r.x = longint'($signed(p[CW-1:0]));
        r.y = longint'($signed(p[2*CW-1:CW]));
        r.z = longint'($signed(p[3*CW-1:2*CW]));
        return r;
    endfunction

    function automatic vec_t vsub(vec_t a, vec_t b);
        vec_t r;
        r.x = a.x - b.x;
        r.y = a.y - b.y;
        r.z = a.z - b.z;
        return r;
    endfunction

    // exact cross product, then floor by the fraction bits
    function automatic vec_t vcross(vec_t a, vec_t b);
        vec_t r;
        r.x = (a.y * b.z - a.z * b.y) >>> FB;
        r.y = (a.z * b.x - a.x * b.z) >>> FB;
        r.z = (a.x * b.y - a.y * b.x) >>> FB;
        return r;
    endfunction

    function automatic longint vdot(vec_t a, vec_t b);
        return a.x * b.x + a.y * b.y + a.z * b.z;
    endfunction

    function automatic longint unsigned quot_q20(longint unsigned mag, longint unsigned den,
                                                 longint unsigned cap);
        longint unsigned q, r, res;
        q = mag / den;
        r = mag % den;
        if (q > (cap >> Q_FRAC))
            return cap;
        res = q << Q_FRAC;
        for (int i = Q_FRAC - 1; i >= 0; i--)
        begin
            r = r << 1;
            if (r >= den)
            begin
                r = r - den;
                res = res | (64'd1 << i);
            end
        end
        return (res < cap) ? res : cap;
    endfunction

    function automatic longint signed_bary(longint num, longint unsigned den);
        if (num < 0)
            return -longint'(quot_q20(longint'(-num), den, UV_CAP));
        return longint'(quot_q20(num, den, UV_CAP));
    endfunction

    function automatic bit triangle_hit(vec_t o, vec_t dir, vec_t a, vec_t b, vec_t c,
                                        output longint unsigned t_out);
        vec_t e1, e2, s, p, q;
        longint det, nu, nv, nt, tol, u, v;
        longint unsigned t;
        t_out = 0;
        e1 = vsub(b, a);
        e2 = vsub(c, a);
        s = vsub(o, a);
        p = vcross(dir, e2);
        q = vcross(s, e1);
        det = vdot(e1, p);
        nu = vdot(s, p);
        nv = vdot(dir, q);
        nt = vdot(e2, q);
        tol = longint'(cfg.bary_tolerance);
        if (det < 0)
        begin
            det = -det;
            nu = -nu;
            nv = -nv;
            nt = -nt;
        end
        if (det == 0 || det < longint'(cfg.parallel_threshold))
            return 0;
        u = signed_bary(nu, det);
        if (u < -tol || u > ONE + tol)
            return 0;
        v = signed_bary(nv, det);
        if (v < -tol || u + v > ONE + tol)
            return 0;
        if (nt <= 0)
            return 0;
        t = quot_q20(nt, det, T_MAX);
        if (t <= tol)
            return 0;
        t_out = t;
        return 1;
    endfunction

    function automatic isect_t predict_isect(logic [IN_DATA_WIDTH-1:0] d, logic quad);
        vec_t o, dir, a, b, c, e;
        longint unsigned t;
        isect_t r;
        o   = unpack_vec(d[0*VEC_WIDTH +: VEC_WIDTH]);
        dir = unpack_vec(d[1*VEC_WIDTH +: VEC_WIDTH]);
        a   = unpack_vec(d[2*VEC_WIDTH +: VEC_WIDTH]);
        b   = unpack_vec(d[3*VEC_WIDTH +: VEC_WIDTH]);
        c   = unpack_vec(d[4*VEC_WIDTH +: VEC_WIDTH]);
        e   = unpack_vec(d[5*VEC_WIDTH +: VEC_WIDTH]);
        r = '{hit: 1'b0, distance: '0, second: 1'b0};
        if (triangle_hit(o, dir, a, b, c, t))
        begin
            r.hit = 1'b1;
            r.distance = t[T_BITS-1:0];
        end
        else if (quad && triangle_hit(o, dir, a, c, e, t))
        begin
            r.hit = 1'b1;
            r.distance = t[T_BITS-1:0];
            r.second = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch at result %0d: %s got %0h, expected %0h", n_out, what, got, want);
        fails++;
    endtask

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.parallel_threshold <= CFG_WIDTH'(1);
            cfg.bary_tolerance <= CFG_WIDTH'(1);
            fails <= 0;
            hits <= 0;
            quad_hits <= 0;
            n_out <= 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_PARALLEL)
                    cfg.parallel_threshold <= cfg_wdata;
                else if (cfg_index == REG_TOL)
                    cfg.bary_tolerance <= cfg_wdata;
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(predict_isect(s_tdata, s_tuser[0]));
            if (m_tvalid && m_tready)
            begin
                isect_t want;
                if (expected_q.size() == 0)
                begin
                    $display("unexpected result word %0d", n_out);
                    fails++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (m_tuser[0] !== want.hit)
                        report_mismatch("hit", m_tuser[0], want.hit);
                    if (m_tdata !== want.distance)
                        report_mismatch("distance", m_tdata, want.distance);
                    if (m_tuser[1] !== want.second)
                        report_mismatch("second_triangle", m_tuser[1], want.second);
                    if (want.hit)
                        hits++;
                    if (want.second)
                        quad_hits++;
                end
                n_out++;
            end
        end
    end

endmodule

FILE: bench/ray_triangle_quad_intersect_test.sv
// Testbench top for the ray/triangle/quad intersection block: drives rays and primitives
// with random gaps and stalls across several register settings and gives the verdict.
// Depends on rtqi_pkg, ray_triangle_quad_intersect and ray_triangle_quad_intersect_check.
module ray_triangle_quad_intersect_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rtqi_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int RANDOM_ITEMS = 1250;
    localparam int STALL_LIMIT = 4000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_DATA_WIDTH-1:0]  s_tdata = '0;
    logic [0:0]                s_tuser = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_DATA_WIDTH-1:0] m_tdata;
    logic [1:0]                m_tuser;
    logic                      cfg_we = 1'b0;
    logic [0:0]                cfg_index = REG_PARALLEL;
    logic [CFG_WIDTH-1:0]      cfg_wdata = '0;
    int fails, pending, hits, quad_hits;
    int n_sent = 0;
    int idle_cycles = 0;
    bit no_gaps = 0;

    ray_triangle_quad_intersect uut (.*);

    ray_triangle_quad_intersect_check checker_i (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        return no_gaps ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic logic [VEC_WIDTH-1:0] pack_vec(int x, int y, int z);
        logic [CW-1:0] px, py, pz;
        px = x[CW-1:0];
        py = y[CW-1:0];
        pz = z[CW-1:0];
        return {pz, py, px};
    endfunction

    function automatic int coord(int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic logic [VEC_WIDTH-1:0] noise_vec();
        return VEC_WIDTH'({$urandom(), $urandom()});
    endfunction

    function automatic logic pick_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic send_word(logic [IN_DATA_WIDTH-1:0] d, logic quad);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= quad;
        do @(posedge clk); while (!s_tready);
        n_sent++;
    endtask

    // aim the ray near the centroid of abc or acd so that most words reach the distance test
    task automatic send_aimed(int r, bit quad, bit aim_second);
        int a[3], b[3], c[3], e[3], o[3], dir[3];
        int tgt, jit;
        jit = $urandom_range(0, 3) == 0 ? r : r / 8;
        for (int k = 0; k < 3; k++)
        begin
            a[k] = coord(r);
            b[k] = coord(r);
            c[k] = coord(r);
            e[k] = coord(r);
            o[k] = coord(r);
            tgt = aim_second ? (a[k] + c[k] + e[k]) / 3 : (a[k] + b[k] + c[k]) / 3;
            dir[k] = tgt + coord(jit) - o[k];
            if ($urandom_range(0, 9) == 0)
                dir[k] = -dir[k];
        end
        send_word({pack_vec(e[0], e[1], e[2]), pack_vec(c[0], c[1], c[2]),
                   pack_vec(b[0], b[1], b[2]), pack_vec(a[0], a[1], a[2]),
                   pack_vec(dir[0], dir[1], dir[2]), pack_vec(o[0], o[1], o[2])}, quad);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [CFG_WIDTH-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_thresholds(logic [CFG_WIDTH-1:0] par, logic [CFG_WIDTH-1:0] tol);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TRI_LATENCY + 4) @(posedge clk);
        write_reg(REG_PARALLEL, par);
        write_reg(REG_TOL, tol);
    endtask

    // draw a stall before each result word
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[ray_triangle_quad_intersect] ERROR");
            $finish;
        end
    end

    initial
    begin
        int sel, r;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: degenerate, extreme and hand-placed primitives at reset thresholds
        send_word('0, 1'b0);
        send_word('1, 1'b1);
        send_word({6{pack_vec(-(1 << (CW - 1)), (1 << (CW - 1)) - 1, 0)}}, 1'b1);
        send_word({6{pack_vec((1 << (CW - 1)) - 1, -(1 << (CW - 1)), 1)}}, 1'b0);
        // ray down z toward a triangle in the z=0 plane, passing outside abc
        send_word({pack_vec(0, 2048, 0), pack_vec(2048, 0, 0), pack_vec(0, 1024, 0),
                   pack_vec(1024, 0, 0), pack_vec(0, 0, -1024), pack_vec(100, 100, 1024)},
                  1'b0);
        // unit-square quad, point past abc's hypotenuse lands in acd
        send_word({pack_vec(1024, 1024, 0), pack_vec(0, 1024, 0), pack_vec(1024, 0, 0),
                   pack_vec(0, 0, 0), pack_vec(0, 0, -1024), pack_vec(800, 800, 1024)}, 1'b1);
        // ray pointing away
        send_word({pack_vec(1024, 1024, 0), pack_vec(0, 1024, 0), pack_vec(1024, 0, 0),
                   pack_vec(0, 0, 0), pack_vec(0, 0, 1024), pack_vec(100, 100, 1024)}, 1'b1);
        // ray parallel to the plane
        send_word({pack_vec(1024, 1024, 0), pack_vec(0, 1024, 0), pack_vec(1024, 0, 0),
                   pack_vec(0, 0, 0), pack_vec(1024, 0, 0), pack_vec(100, 100, 1024)}, 1'b1);
        // hit exactly on a vertex and an edge, and a very long distance
        send_word({pack_vec(0, 0, 0), pack_vec(0, 1024, 0), pack_vec(1024, 0, 0),
                   pack_vec(0, 0, 0), pack_vec(0, 0, -1024), pack_vec(0, 0, 1024)}, 1'b0);
        send_word({pack_vec(0, 0, 0), pack_vec(0, 1024, 0), pack_vec(1024, 0, 0),
                   pack_vec(0, 0, 0), pack_vec(0, 0, -1), pack_vec(512, 512, 500000)}, 1'b0);
        send_word({pack_vec(0, 0, 0), pack_vec(0, 1024, 0), pack_vec(1024, 0, 0),
                   pack_vec(0, 0, 0), pack_vec(0, 0, -1024), pack_vec(512, 0, 1)}, 1'b0);
        for (int i = 0; i < 8; i++)
            send_aimed(1 << (6 + 2 * i), i[0], i[1]);

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: set_thresholds(CFG_WIDTH'(0), CFG_WIDTH'(0));
                1: set_thresholds('1, '1);
                2: set_thresholds(CFG_WIDTH'(1), CFG_WIDTH'(1));
                3: set_thresholds(CFG_WIDTH'($urandom_range(0, 4095)),
                                  CFG_WIDTH'($urandom_range(0, 65535)));
                default: set_thresholds(CFG_WIDTH'($urandom()), CFG_WIDTH'($urandom()));
            endcase
            for (int i = 0; i < RANDOM_ITEMS / 5; i++)
            begin
                if (i % 100 == 0)
                    no_gaps = ($urandom_range(0, 2) == 0);
                sel = $urandom_range(0, 19);
                r = 1 << $urandom_range(4, 17);
                if (sel < 14)
                    send_aimed(r, pick_bit(), pick_bit());
                else if (sel < 17)
                    send_word({noise_vec(), noise_vec(), noise_vec(), noise_vec(),
                               noise_vec(), noise_vec()}, pick_bit());
                else
                    send_word({pack_vec(coord(r), coord(r), coord(r)),
                               pack_vec(coord(r), coord(r), coord(r)),
                               pack_vec(coord(r), coord(r), coord(r)),
                               pack_vec(coord(r), coord(r), coord(r)),
                               pack_vec(coord(r), coord(r), coord(r)),
                               pack_vec(coord(r), coord(r), coord(r))}, pick_bit());
            end
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TRI_LATENCY + 4) @(posedge clk);

        $display("sent %0d words over five threshold settings", n_sent);
        $display("%0d hits, %0d of them on the second triangle of a quad", hits, quad_hits);
        if (fails == 0)
            $display("[ray_triangle_quad_intersect] OK");
        else
            $display("[ray_triangle_quad_intersect] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
sv/rtqi_pkg.sv
sv/rtqi_tri.sv
sv/ray_triangle_quad_intersect.sv
bench/ray_triangle_quad_intersect_check.sv
bench/ray_triangle_quad_intersect_test.sv
